// File: sv/lsched_pkg.sv
// types and constants shared by the lottery scheduler modules
`default_nettype none
package lsched_pkg;

	localparam int unsigned ID_W  = 16;
	localparam int unsigned WT_W  = 8;
	localparam int unsigned RND_W = 16;
	localparam int unsigned QNT_W = 16;
	localparam int unsigned DIV_CNT_W = $clog2(RND_W);

	// operation codes
	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;
	localparam logic [1:0] FUNC_NONE   = 2'd3;

	// result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_MISSING = 2'd2;
	localparam logic [1:0] STATUS_EMPTY   = 2'd3;

	typedef struct packed {
		logic [1:0]       func;
		logic [ID_W-1:0]  task_id;
		logic [WT_W-1:0]  weight;
		logic [RND_W-1:0] random_value;
	} ls_in_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [ID_W-1:0] winner_id;
		logic            winner_valid;
		logic            drew;
	} ls_out_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [WT_W-1:0] weight;
	} ls_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RM_RD,
		ST_RM_CMP,
		ST_SH_RD,
		ST_SH_WR,
		ST_DIV,
		ST_SC_RD,
		ST_SC_CMP,
		ST_FIN
	} ls_state_t;

	// controller to datapath
	typedef struct packed {
		logic       capture;
		logic       add;
		logic       rm_init;
		logic       rd;
		logic       rd_next;
		logic       ptr_dec;
		logic       ptr_inc;
		logic       sub_total;
		logic       shift_wr;
		logic       rm_done;
		logic       q_dec;
		logic       div_start;
		logic       div_step;
		logic       sc_start;
		logic       sc_adv;
		logic       select;
		logic       draw;
		logic       set_status;
		logic [1:0] status;
		logic       out_load;
	} ls_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] func;
		logic       full;
		logic       count_zero;
		logic       total_zero;
		logic       quantum_zero;
		logic       match;
		logic       ptr_zero;
		logic       ptr_last;
		logic       shift_last;
		logic       div_last;
		logic       hit;
		logic       out_free;
	} ls_sts_t;

endpackage
`default_nettype wire

// File: sv/lottery_scheduler.sv
// top level of the weighted lottery scheduler
//
// Weighted lottery scheduler over a table of up to MAX_ENTRIES tasks held in
// insertion order, each owning a consecutive range of tickets. One input beat
// (add, remove or tick) gives exactly one result beat. Items are handled one
// at a time by a state machine stepping a table memory with one write and one
// registered read port: an add writes the new entry at the end; a remove reads
// and compares entries from the newest end, then moves each later entry down
// by a read and a write; a tick that only counts the quantum decrements it, and
// a tick that draws runs a bit-serial remainder, then scans from the oldest
// entry, with a read state and a compare state per entry. A new item is taken
// as soon as the previous result sits in the output register, even while it is
// stalled. The user must write quantum_reload through cfg_we/cfg_wdata only
// while idle; the block itself does not enforce this.
`default_nettype none
module lottery_scheduler #(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  lsched_pkg::ls_in_t      in_data,
	output logic                    out_valid,
	input  wire                     out_stall,
	output lsched_pkg::ls_out_t     out_data,
	input  wire                     cfg_we,
	input  wire [lsched_pkg::QNT_W-1:0] cfg_wdata
);
	import lsched_pkg::*;

	ls_cmd_t cmd;
	ls_sts_t sts;

	// sequencer
	lsched_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table and arithmetic
	lsched_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire

// File: sv/lsched_ctrl.sv
// sequencing state machine of the lottery scheduler
`default_nettype none
module lsched_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  lsched_pkg::ls_sts_t sts,
	output lsched_pkg::ls_cmd_t cmd
);
	import lsched_pkg::*;

	ls_state_t state_q;
	ls_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				unique case (sts.func)
					FUNC_REMOVE: state_d = sts.count_zero ? ST_FIN : ST_RM_RD;
					FUNC_TICK: begin
						if (sts.count_zero || sts.total_zero || !sts.quantum_zero) begin
							state_d = ST_FIN;
						end else begin
							state_d = ST_DIV;
						end
					end
					default: state_d = ST_FIN;
				endcase
			end
			ST_RM_RD: state_d = ST_RM_CMP;
			ST_RM_CMP: begin
				if (sts.match) begin
					state_d = sts.ptr_last ? ST_FIN : ST_SH_RD;
				end else begin
					state_d = sts.ptr_zero ? ST_FIN : ST_RM_RD;
				end
			end
			ST_SH_RD: state_d = ST_SH_WR;
			ST_SH_WR: state_d = sts.shift_last ? ST_FIN : ST_SH_RD;
			ST_DIV: state_d = sts.div_last ? ST_SC_RD : ST_DIV;
			ST_SC_RD: state_d = ST_SC_CMP;
			ST_SC_CMP: state_d = (sts.hit || sts.ptr_last) ? ST_FIN : ST_SC_RD;
			ST_FIN: state_d = sts.out_free ? ST_IDLE : ST_FIN;
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
			end
			ST_DISPATCH: begin
				unique case (sts.func)
					FUNC_ADD: begin
						cmd.set_status = 1'b1;
						if (sts.full) begin
							cmd.status = STATUS_FULL;
						end else begin
							cmd.add    = 1'b1;
							cmd.status = STATUS_OK;
						end
					end
					FUNC_REMOVE: begin
						if (sts.count_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = STATUS_MISSING;
						end else begin
							cmd.rm_init = 1'b1;
						end
					end
					FUNC_TICK: begin
						priority if (sts.count_zero || sts.total_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = STATUS_EMPTY;
						end else if (!sts.quantum_zero) begin
							cmd.q_dec      = 1'b1;
							cmd.set_status = 1'b1;
							cmd.status     = STATUS_OK;
						end else begin
							cmd.div_start = 1'b1;
						end
					end
					default: begin
						cmd.set_status = 1'b1;
						cmd.status     = STATUS_OK;
					end
				endcase
			end
			ST_RM_RD: begin
				cmd.rd = 1'b1;
			end
			ST_RM_CMP: begin
				if (sts.match) begin
					cmd.sub_total = 1'b1;
					if (sts.ptr_last) begin
						cmd.rm_done    = 1'b1;
						cmd.set_status = 1'b1;
						cmd.status     = STATUS_OK;
					end
				end else if (sts.ptr_zero) begin
					cmd.set_status = 1'b1;
					cmd.status     = STATUS_MISSING;
				end else begin
					cmd.ptr_dec = 1'b1;
				end
			end
			ST_SH_RD: begin
				cmd.rd      = 1'b1;
				cmd.rd_next = 1'b1;
			end
			ST_SH_WR: begin
				cmd.shift_wr = 1'b1;
				cmd.ptr_inc  = 1'b1;
				if (sts.shift_last) begin
					cmd.rm_done    = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status     = STATUS_OK;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.sc_start = sts.div_last;
			end
			ST_SC_RD: begin
				cmd.rd = 1'b1;
			end
			ST_SC_CMP: begin
				if (sts.hit || sts.ptr_last) begin
					cmd.select     = sts.hit;
					cmd.draw       = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status     = STATUS_OK;
				end else begin
					cmd.sc_adv  = 1'b1;
					cmd.ptr_inc = 1'b1;
				end
			end
			ST_FIN: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: sv/lsched_dp.sv
// task table, counters, remainder unit and output register of the scheduler
`default_nettype none
module lsched_dp #(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  lsched_pkg::ls_in_t      in_data,
	input  wire                     cfg_we,
	input  wire [lsched_pkg::QNT_W-1:0] cfg_wdata,
	input  wire                     out_stall,
	output logic                    out_valid,
	output lsched_pkg::ls_out_t     out_data,
	input  lsched_pkg::ls_cmd_t     cmd,
	output lsched_pkg::ls_sts_t     sts
);
	import lsched_pkg::*;

	localparam int unsigned IW = $clog2(MAX_ENTRIES);
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned TW = $clog2(MAX_ENTRIES * ((1 << WT_W) - 1) + 1);

	ls_in_t              item_q;
	ls_entry_t           mem [MAX_ENTRIES];
	ls_entry_t           rd_q;
	logic [CW-1:0]       count_q;
	logic [TW-1:0]       total_q;
	logic [QNT_W-1:0]    quantum_q;
	logic [QNT_W-1:0]    reload_q;
	logic [ID_W-1:0]     cur_task_q;
	logic                cur_valid_q;
	logic [IW-1:0]       ptr_q;
	logic [TW-1:0]       rem_q;
	logic [RND_W-1:0]    rnd_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [TW-1:0]       base_q;
	logic [1:0]          status_q;
	logic                drew_q;
	logic                out_valid_q;
	ls_out_t             out_q;

	logic [IW-1:0]       rd_addr;
	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	ls_entry_t           wr_data;
	logic [TW:0]         rem_sh;
	logic [TW:0]         rem_diff;
	logic [TW-1:0]       top;
	logic                out_free;

	// input beat capture
	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= in_data;
	end

	// quantum reload register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= '0;
		end else if (cfg_we) begin
			reload_q <= cfg_wdata;
		end
	end

	// table memory, one write and one registered read per cycle
	assign rd_addr = cmd.rd_next ? (ptr_q + IW'(1)) : ptr_q;
	assign wr_en   = cmd.add || cmd.shift_wr;
	assign wr_addr = cmd.add ? count_q[IW-1:0] : ptr_q;
	assign wr_data = cmd.add ? ls_entry_t'{id: item_q.task_id, weight: item_q.weight} : rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) rd_q <= mem[rd_addr];
	end

	// entry count and ticket total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else begin
			if (cmd.add) begin
				count_q <= count_q + CW'(1);
				total_q <= total_q + TW'(item_q.weight);
			end else begin
				if (cmd.rm_done)   count_q <= count_q - CW'(1);
				if (cmd.sub_total) total_q <= total_q - TW'(rd_q.weight);
			end
		end
	end

	// table pointer
	always_ff @(posedge clk) begin
		priority if (cmd.rm_init) begin
			ptr_q <= IW'(count_q - CW'(1));
		end else if (cmd.sc_start) begin
			ptr_q <= '0;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + IW'(1);
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - IW'(1);
		end
	end

	// restoring remainder, one bit of the random value a cycle
	assign rem_sh   = {rem_q, rnd_q[RND_W-1]};
	assign rem_diff = rem_sh - {1'b0, total_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q     <= '0;
			rnd_q     <= item_q.random_value;
			div_cnt_q <= DIV_CNT_W'(RND_W - 1);
		end else if (cmd.div_step) begin
			rem_q     <= rem_diff[TW] ? rem_sh[TW-1:0] : rem_diff[TW-1:0];
			rnd_q     <= {rnd_q[RND_W-2:0], 1'b0};
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
	end

	// range scan base
	assign top = base_q + TW'(rd_q.weight);

	always_ff @(posedge clk) begin
		if (cmd.sc_start) begin
			base_q <= '0;
		end else if (cmd.sc_adv) begin
			base_q <= top;
		end
	end

	// quantum and selection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q   <= '0;
			cur_task_q  <= '0;
			cur_valid_q <= 1'b0;
		end else begin
			if (cmd.q_dec) quantum_q <= quantum_q - QNT_W'(1);
			if (cmd.draw)  quantum_q <= reload_q;
			if (cmd.select) begin
				cur_task_q  <= rd_q.id;
				cur_valid_q <= 1'b1;
			end
			if (cmd.rm_done && count_q == CW'(1)) cur_valid_q <= 1'b0;
		end
	end

	// result status and draw flag
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			drew_q <= 1'b0;
		end else if (cmd.draw) begin
			drew_q <= 1'b1;
		end
		if (cmd.set_status) status_q <= cmd.status;
	end

	// output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.status       <= status_q;
			out_q.winner_id    <= cur_valid_q ? cur_task_q : '0;
			out_q.winner_valid <= cur_valid_q;
			out_q.drew         <= drew_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// status to the controller
	always_comb begin
		sts              = '0;
		sts.func         = item_q.func;
		sts.full         = (count_q == CW'(MAX_ENTRIES));
		sts.count_zero   = (count_q == '0);
		sts.total_zero   = (total_q == '0);
		sts.quantum_zero = (quantum_q == '0);
		sts.match        = (rd_q.id == item_q.task_id);
		sts.ptr_zero     = (ptr_q == '0);
		sts.ptr_last     = (CW'(ptr_q) + CW'(1) == count_q);
		sts.shift_last   = (CW'(ptr_q) + CW'(2) == count_q);
		sts.div_last     = (div_cnt_q == '0);
		sts.hit          = (rem_q < top);
		sts.out_free     = out_free;
	end

	// table never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above table depth");

	// an empty table holds no tickets
	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (total_q == '0))
		else $error("tickets left in an empty table");

	// drawn ticket lies below the total when the scan starts
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sc_start |=> (rem_q < total_q))
		else $error("drawn ticket outside the ticket range");

	// a draw always leaves a selected task
	a_draw_selects: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw |=> cur_valid_q)
		else $error("draw finished without a selection");

	// winner id reads zero while nothing is selected
	a_winner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.winner_valid) |-> (out_q.winner_id == '0))
		else $error("winner id set without a selection");

endmodule
`default_nettype wire
